// ===== sv/rpn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN evaluator package
// Shared sizes, token and status codes, and the cell and divider types.
// ----------------------------------------------------------------------------
package rpn_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int KIND_W      = 3;
    localparam int DEPTH_W     = 5;
    localparam int STATUS_W    = 3;
    localparam int DIVD_W      = DATA_W + FRAC_W;
    localparam int DIV_CNT_W   = $clog2(DIVD_W);
    localparam int PROD_W      = 2 * DATA_W;

    localparam logic [KIND_W-1:0] KIND_PUSH = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SUB  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MUL  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DIV  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVER  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZ  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SAT   = 3'd4;

    localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_TAKE_UP,
        CELL_TAKE_DN
    } t_cell_op;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

// ===== sv/rpn_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN evaluator channels
// Token channel and result channel, each with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rpn_tok_if import rpn_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface rpn_res_if import rpn_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] top_value;
    logic [DEPTH_W-1:0]       depth;
    logic [STATUS_W-1:0]      status;

    modport source (output valid, output top_value, output depth, output status,
                    input ready);
    modport sink   (input valid, input top_value, input depth, input status,
                    output ready);
endinterface

// ===== sv/rpn_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN stack cell
// One stack entry; takes its shallower or deeper neighbor's value, or holds.
// ----------------------------------------------------------------------------
module rpn_cell import rpn_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell_op                 i_op,
    input  logic signed [DATA_W-1:0] i_up,
    input  logic signed [DATA_W-1:0] i_dn,
    output logic signed [DATA_W-1:0] o_entry
);

    logic signed [DATA_W-1:0] r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else begin
            unique case (i_op)
                CELL_TAKE_UP: r_entry <= i_up;
                CELL_TAKE_DN: r_entry <= i_dn;
                default:      r_entry <= r_entry;
            endcase
        end
    end

    assign o_entry = r_entry;

endmodule

// ===== sv/rpn_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN restoring divider
// Unsigned magnitude divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpn_div import rpn_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    output t_div_status       o_stat,
    output logic [DIVD_W-1:0] o_quot
);

    logic [DATA_W-1:0]    r_rem;
    logic [DIVD_W-1:0]    r_quo;
    logic [DATA_W-1:0]    r_dvs;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DATA_W:0]      w_rem_sh;
    logic [DATA_W:0]      w_diff;

    assign w_rem_sh = {r_rem, r_quo[DIVD_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift together; no reset needed on the data path.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!w_diff[DATA_W]) begin
                r_rem <= w_diff[DATA_W-1:0];
                r_quo <= {r_quo[DIVD_W-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh[DATA_W-1:0];
                r_quo <= {r_quo[DIVD_W-2:0], 1'b0};
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quo;

endmodule

// ===== sv/rpn_stack_calculator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN stack calculator unit
// Evaluates reverse Polish tokens on a bounded stack of signed Q16.16 values.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload                          Meaning
//  i_tok     in   kind[2:0], value[31:0]           one token per transfer
//  o_res     out  top_value[31:0], depth, status   one result per token
//
// Push, add, subtract, error and unknown tokens finish in the accept cycle:
// the result is loaded into the output register at the end of that cycle.
// Multiply registers the 32x32 product first and loads the result from the
// multiply state. Divide runs a restoring divider at one bit per cycle over
// the 48-bit scaled dividend and loads the result when the divider is done.
// One token is in work at a time; a new token is taken while the previous
// result is still waiting, as long as that result transfers in the same cycle.
// Reset is synchronous, active low, and clears the stack to all zero.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_unit import rpn_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rpn_tok_if.sink    i_tok,
    rpn_res_if.source  o_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV
    } t_state;

    t_state r_state, n_state;

    // The stack is a row of cells; cell 0 is the top. Cells past the count
    // always hold zero, so cell 0 is also the reported top of an empty stack.
    logic signed [DATA_W-1:0] w_entry [STACK_DEPTH];
    logic signed [DATA_W-1:0] w_up    [STACK_DEPTH];
    logic signed [DATA_W-1:0] w_dn    [STACK_DEPTH];
    t_cell_op                 w_op    [STACK_DEPTH];

    logic [CNT_W-1:0]         r_count;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_top;
    logic [DEPTH_W-1:0]       r_depth;
    logic [STATUS_W-1:0]      r_status;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_div_neg;

    logic                     w_accept;
    logic                     w_push;
    logic                     w_pop;
    logic signed [DATA_W-1:0] w_res;
    logic                     n_load;
    logic signed [DATA_W-1:0] n_top;
    logic [CNT_W-1:0]         n_count;
    logic [STATUS_W-1:0]      n_status;
    logic                     w_div_start;

    logic signed [DATA_W-1:0] w_a;
    logic signed [DATA_W-1:0] w_b;
    logic signed [DATA_W:0]   w_sum;
    logic [DATA_W-1:0]        w_mag_a;
    logic [DATA_W-1:0]        w_mag_b;
    logic signed [DIVD_W-1:0] w_mul_sh;
    t_div_status              w_div_stat;
    logic [DIVD_W-1:0]        w_quot;

    genvar k;
    generate
        for (k = 0; k < STACK_DEPTH; k++) begin : g_cell
            rpn_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_op    (w_op[k]),
                .i_up    (w_up[k]),
                .i_dn    (w_dn[k]),
                .o_entry (w_entry[k])
            );
        end
    endgenerate

    // Push shifts every cell one place deeper; an operator shifts every cell
    // below the top one place shallower and loads the result into the top.
    always_comb begin
        for (int i = 0; i < STACK_DEPTH; i++) begin
            w_up[i] = (i == 0) ? w_res : w_entry[(i == 0) ? 0 : i - 1];
            w_dn[i] = (i == STACK_DEPTH - 1) ? '0
                                             : w_entry[(i == STACK_DEPTH - 1) ? i : i + 1];
            if (w_push) begin
                w_op[i] = CELL_TAKE_UP;
            end else if (w_pop) begin
                w_op[i] = (i == 0) ? CELL_TAKE_UP : CELL_TAKE_DN;
            end else begin
                w_op[i] = CELL_HOLD;
            end
        end
    end

    assign w_a = w_entry[1];
    assign w_b = w_entry[0];
    assign w_sum = (i_tok.kind == KIND_SUB) ? ({w_a[DATA_W-1], w_a} - {w_b[DATA_W-1], w_b})
                                            : ({w_a[DATA_W-1], w_a} + {w_b[DATA_W-1], w_b});
    assign w_mag_a  = w_a[DATA_W-1] ? (~w_a + 1'b1) : w_a;
    assign w_mag_b  = w_b[DATA_W-1] ? (~w_b + 1'b1) : w_b;
    // An arithmetic shift of the product is the floor of the division by 2^16.
    assign w_mul_sh = r_prod[PROD_W-1:FRAC_W];

    rpn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({w_mag_a, {FRAC_W{1'b0}}}),
        .i_divisor  (w_mag_b),
        .o_stat     (w_div_stat),
        .o_quot     (w_quot)
    );

    assign i_tok.ready = (r_state == S_IDLE) && (!r_out_valid || o_res.ready);
    assign w_accept    = i_tok.valid && i_tok.ready;

    always_comb begin
        n_state     = r_state;
        n_load      = 1'b0;
        n_top       = w_b;
        n_count     = r_count;
        n_status    = ST_OK;
        w_push      = 1'b0;
        w_pop       = 1'b0;
        w_res       = i_tok.value;
        w_div_start = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_load = 1'b1;
                    if (i_tok.kind == KIND_PUSH) begin
                        if (r_count >= CNT_W'(STACK_DEPTH)) begin
                            n_status = ST_OVER;
                        end else begin
                            w_push  = 1'b1;
                            n_top   = i_tok.value;
                            n_count = r_count + 1'b1;
                        end
                    end else if (i_tok.kind == KIND_ADD || i_tok.kind == KIND_SUB ||
                                 i_tok.kind == KIND_MUL || i_tok.kind == KIND_DIV) begin
                        if (r_count < CNT_W'(2)) begin
                            n_status = ST_UNDER;
                        end else if (i_tok.kind == KIND_MUL) begin
                            n_load  = 1'b0;
                            n_state = S_MUL;
                        end else if (i_tok.kind == KIND_DIV) begin
                            if (w_b == '0) begin
                                n_status = ST_DIVZ;
                            end else begin
                                n_load      = 1'b0;
                                w_div_start = 1'b1;
                                n_state     = S_DIV;
                            end
                        end else begin
                            // Add and subtract saturate on the 33-bit sum.
                            w_pop   = 1'b1;
                            n_count = r_count - 1'b1;
                            if (w_sum[DATA_W] != w_sum[DATA_W-1]) begin
                                w_res    = w_sum[DATA_W] ? Q_MIN : Q_MAX;
                                n_status = ST_SAT;
                            end else begin
                                w_res = w_sum[DATA_W-1:0];
                            end
                            n_top = w_res;
                        end
                    end
                end
            end
            S_MUL: begin
                w_pop   = 1'b1;
                n_load  = 1'b1;
                n_count = r_count - 1'b1;
                n_state = S_IDLE;
                if (w_mul_sh[DIVD_W-1:DATA_W-1] != {(FRAC_W+1){w_mul_sh[DIVD_W-1]}}) begin
                    w_res    = w_mul_sh[DIVD_W-1] ? Q_MIN : Q_MAX;
                    n_status = ST_SAT;
                end else begin
                    w_res = w_mul_sh[DATA_W-1:0];
                end
                n_top = w_res;
            end
            S_DIV: begin
                w_res = '0;
                if (w_div_stat.done) begin
                    w_pop   = 1'b1;
                    n_load  = 1'b1;
                    n_count = r_count - 1'b1;
                    n_state = S_IDLE;
                    // Negative quotients may reach one step further than positive.
                    if (!r_div_neg) begin
                        if (w_quot[DIVD_W-1:DATA_W-1] != '0) begin
                            w_res    = Q_MAX;
                            n_status = ST_SAT;
                        end else begin
                            w_res = w_quot[DATA_W-1:0];
                        end
                    end else begin
                        if (w_quot[DIVD_W-1:DATA_W] != '0 ||
                            (w_quot[DATA_W-1] && w_quot[DATA_W-2:0] != '0)) begin
                            w_res    = Q_MIN;
                            n_status = ST_SAT;
                        end else begin
                            w_res = ~w_quot[DATA_W-1:0] + 1'b1;
                        end
                    end
                    n_top = w_res;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (n_load) begin
                r_out_valid <= 1'b1;
                r_top       <= n_top;
                r_depth     <= DEPTH_W'(n_count);
                r_status    <= n_status;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Operand side data: product and quotient sign, captured at accept.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prod    <= w_a * w_b;
            r_div_neg <= w_a[DATA_W-1] ^ w_b[DATA_W-1];
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.top_value = r_top;
    assign o_res.depth     = r_depth;
    assign o_res.status    = r_status;

`ifndef SYNTHESIS
    a_push_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_tok.kind == KIND_PUSH && r_count < CNT_W'(STACK_DEPTH))
        |=> (o_res.valid && o_res.depth == DEPTH_W'($past(r_count) + 1'b1)))
        else $error("push result missing or depth wrong");

    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.busy |-> (r_state == S_DIV))
        else $error("divider busy outside divide state");

    a_mul_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> !r_out_valid)
        else $error("output register occupied when product lands");
`endif

endmodule
